// ----- rtl/dta_pkg.sv -----
package dta_pkg;

  localparam int IDX_W       = 8;
  localparam int IDX_SPACE   = 256;
  localparam int SEL_W       = 11;
  localparam int DESC_W      = 64;
  localparam int BASE_W      = 32;
  localparam int LIMIT_W     = 20;
  localparam int TYPE_W      = 8;
  localparam int DPL_W       = 2;
  localparam int DPL_LSB     = 45;
  localparam int CHUNK_W     = 32;
  localparam int POS_W       = 5;
  localparam int DEF_ENTRIES = 256;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_SPARE  = 2'd3
  } op_t;

  localparam logic ERR_OK   = 1'b0;
  localparam logic ERR_FULL = 1'b1;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  pos;
  } scan_hit_t;

  // Pack base, limit, type byte and granularity; flag nibble is {G, 1, 0, 0}.
  function automatic logic [DESC_W-1:0] pack_desc(
    input logic [BASE_W-1:0]  base,
    input logic [LIMIT_W-1:0] limit,
    input logic [TYPE_W-1:0]  typ,
    input logic               gran
  );
    return {base[31:24], gran, 3'b100, limit[19:16], typ, base[23:0], limit[15:0]};
  endfunction

  // Lowest clear bit of one occupancy chunk.
  function automatic scan_hit_t first_zero(input logic [CHUNK_W-1:0] v);
    scan_hit_t h;
    h.found = 1'b0;
    h.pos   = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (!v[i]) begin
        h.found = 1'b1;
        h.pos   = POS_W'(i);
      end
    end
    return h;
  endfunction

endpackage

// ----- rtl/dta_ram.sv -----
module dta_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/descriptor_table_allocator_unit.sv -----
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+---------------------------------------------
// in_      | input     | in_valid / in_ready  | opcode, seg_base, seg_limit, access_type,
//          |           |                      | granularity, entry_index
// out_     | output    | out_valid / out_ready| result_index, selector, occupied,
//          |           |                      | descriptor, error_code
//
// Flow: one item at a time. Create scans the occupancy map 32 entries per cycle
//   through one shared priority encoder, chunk by chunk until a free entry or the
//   last chunk, then hands off. Query issues the registered descriptor RAM read on
//   accept, uses it in S_READ, then hands off; delete goes straight to hand-off.
// Reset: rst_n (synchronous, active low) marks entry 0 in use and frees the rest at
//   once; the descriptor RAM is not cleared and holds garbage until written.
// Stalls: the finished item sits in a result stage and then the output register, so
//   a new item is taken while the previous result waits on out_ready.
module descriptor_table_allocator_unit
  import dta_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_opcode,
  input  logic [BASE_W-1:0]   in_seg_base,
  input  logic [LIMIT_W-1:0]  in_seg_limit,
  input  logic [TYPE_W-1:0]   in_access_type,
  input  logic                in_granularity,
  input  logic [IDX_W-1:0]    in_entry_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    out_result_index,
  output logic [SEL_W-1:0]    out_selector,
  output logic                out_occupied,
  output logic [DESC_W-1:0]   out_descriptor,
  output logic                out_error_code
);

  // Only entries below the 8-bit index space can ever be reached.
  localparam int SCAN    = (ENTRIES < IDX_SPACE) ? ENTRIES : IDX_SPACE;
  localparam int AW      = $clog2(SCAN);
  localparam int NCHUNK  = (SCAN + CHUNK_W - 1) / CHUNK_W;
  localparam int CNT_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int OCC_PAD = NCHUNK * CHUNK_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_READ = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [SEL_W-1:0]  sel;
    logic              occ;
    logic [DESC_W-1:0] desc;
    logic              err;
  } result_t;

  state_t             state_r,  state_nxt;
  logic [SCAN-1:0]    occ_r,    occ_nxt;
  logic [CNT_W-1:0]   cnt_r,    cnt_nxt;
  logic [IDX_W-1:0]   idx_r,    idx_nxt;
  logic               inr_r,    inr_nxt;
  logic [DESC_W-1:0]  desc_r,   desc_nxt;
  result_t            res_r,    res_nxt;
  result_t            out_r,    out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               accept;
  logic               in_range;
  logic [OCC_PAD-1:0] occ_pad;
  logic [CHUNK_W-1:0] chunk;
  scan_hit_t          hit;
  logic [CNT_W+POS_W-1:0] hit_raw;
  logic [IDX_W-1:0]   found_idx;
  logic               q_hit;

  logic               ram_wr_en;
  logic               ram_rd_en;
  logic [DESC_W-1:0]  ram_rd_data;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign in_range = (int'(in_entry_index) < ENTRIES);

  // Pad the map with busy bits so the last chunk never reports a phantom entry.
  always_comb begin
    occ_pad           = '1;
    occ_pad[SCAN-1:0] = occ_r;
  end

  // Shared scan unit: one chunk of the map per cycle.
  assign chunk     = occ_pad[cnt_r*CHUNK_W +: CHUNK_W];
  assign hit       = first_zero(chunk);
  assign hit_raw   = {cnt_r, hit.pos};
  assign found_idx = IDX_W'(hit_raw);

  assign q_hit = inr_r && occ_r[idx_r[AW-1:0]];

  // Read on query or spare accept, write when the scan lands.
  assign ram_rd_en = accept && (in_opcode != OP_CREATE) && (in_opcode != OP_DELETE);
  assign ram_wr_en = (state_r == S_SCAN) && hit.found;

  dta_ram #(
    .WIDTH (DESC_W),
    .DEPTH (SCAN)
  ) u_desc_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (found_idx[AW-1:0]),
    .wr_data (desc_r),
    .rd_en   (ram_rd_en),
    .rd_addr (in_entry_index[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    inr_nxt       = inr_r;
    desc_nxt      = desc_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    // Drop the output item once taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt  = in_entry_index;
          inr_nxt  = in_range;
          cnt_nxt  = '0;
          desc_nxt = pack_desc(in_seg_base, in_seg_limit, in_access_type,
                               in_granularity);
          case (in_opcode)
            OP_CREATE: begin
              state_nxt = S_SCAN;
            end
            OP_DELETE: begin
              // Free only; the stale RAM word is masked by the map.
              if (in_range) begin
                occ_nxt[in_entry_index[AW-1:0]] = 1'b0;
              end
              res_nxt.idx  = in_entry_index;
              res_nxt.sel  = {in_entry_index, {(SEL_W-IDX_W){1'b0}}};
              res_nxt.occ  = 1'b0;
              res_nxt.desc = '0;
              res_nxt.err  = ERR_OK;
              state_nxt    = S_HOLD;
            end
            default: begin
              state_nxt = S_READ;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit.found) begin
          occ_nxt[found_idx[AW-1:0]] = 1'b1;
          res_nxt.idx  = found_idx;
          res_nxt.sel  = {found_idx, 1'b0, desc_r[DPL_LSB +: DPL_W]};
          res_nxt.occ  = 1'b1;
          res_nxt.desc = desc_r;
          res_nxt.err  = ERR_OK;
          state_nxt    = S_HOLD;
        end else if (cnt_r == CNT_W'(NCHUNK - 1)) begin
          // Table full: leave everything untouched.
          res_nxt.idx  = '0;
          res_nxt.sel  = '0;
          res_nxt.occ  = 1'b0;
          res_nxt.desc = '0;
          res_nxt.err  = ERR_FULL;
          state_nxt    = S_HOLD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_READ: begin
        res_nxt.idx  = idx_r;
        res_nxt.sel  = {idx_r, 1'b0,
                        q_hit ? ram_rd_data[DPL_LSB +: DPL_W] : {DPL_W{1'b0}}};
        res_nxt.occ  = q_hit;
        res_nxt.desc = q_hit ? ram_rd_data : '0;
        res_nxt.err  = ERR_OK;
        state_nxt    = S_HOLD;
      end

      S_HOLD: begin
        // Advance into the output register once it is free.
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= SCAN'(1);
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    inr_r  <= inr_nxt;
    desc_r <= desc_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_r.idx;
  assign out_selector     = out_r.sel;
  assign out_occupied     = out_r.occ;
  assign out_descriptor   = out_r.desc;
  assign out_error_code   = out_r.err;

endmodule

// ----- rtl/dta_checker.sv -----
module dta_checker
  import dta_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [IDX_W-1:0]    out_result_index,
  input logic [SEL_W-1:0]    out_selector,
  input logic                out_occupied,
  input logic [DESC_W-1:0]   out_descriptor,
  input logic                out_error_code
);

  // Hold a stalled output item.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_descriptor)
      && $stable(out_selector) && $stable(out_result_index))
    else $error("output item changed while stalled");

  // One item at a time: busy right after an accept.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item back to back");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code == ERR_FULL) |-> !out_occupied
      && (out_result_index == '0) && (out_descriptor == '0) && (out_selector == '0))
    else $error("table-full result carries data");

  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_occupied |-> (out_descriptor == '0)
      && (out_selector == {out_result_index, 3'b000}))
    else $error("free entry reports a descriptor or DPL");

  a_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_occupied |-> out_selector
      == {out_result_index, 1'b0, out_descriptor[DPL_LSB +: DPL_W]})
    else $error("selector does not match index and DPL");

endmodule

bind descriptor_table_allocator_unit dta_checker u_dta_checker (.*);

// ----- bench/descriptor_answer_checker.sv -----
module descriptor_answer_checker
  import dta_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [BASE_W-1:0] in_seg_base,
  input  logic [LIMIT_W-1:0] in_seg_limit,
  input  logic [TYPE_W-1:0] in_access_type,
  input  logic              in_granularity,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [IDX_W-1:0]  out_result_index,
  input  logic [SEL_W-1:0]  out_selector,
  input  logic              out_occupied,
  input  logic [DESC_W-1:0] out_descriptor,
  input  logic              out_error_code,
  output int                mismatches,
  output int                outstanding
);

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [SEL_W-1:0]  selector;
    logic              used;
    logic [DESC_W-1:0] desc;
    logic              err;
  } answer_t;

  logic              in_use      [IDX_SPACE];
  logic [DESC_W-1:0] table_words [IDX_SPACE];
  answer_t           awaited_answers [$];
  answer_t           wanted;
  answer_t           seen;

  function automatic logic [DESC_W-1:0] build_descriptor(
    input logic [BASE_W-1:0]  base,
    input logic [LIMIT_W-1:0] limit,
    input logic [TYPE_W-1:0]  typ,
    input logic               gran
  );
    logic [DESC_W-1:0] d;
    d        = '0;
    d[15:0]  = limit[15:0];
    d[39:16] = base[23:0];
    d[47:40] = typ;
    d[51:48] = limit[19:16];
    d[55:52] = {gran, 3'b100};
    d[63:56] = base[31:24];
    return d;
  endfunction

  // index*8 + DPL, DPL taken from the type byte inside the descriptor
  function automatic logic [SEL_W-1:0] selector_for(
    input logic [IDX_W-1:0]  idx,
    input logic [DESC_W-1:0] d
  );
    return {idx, 1'b0, d[DPL_LSB+1:DPL_LSB]};
  endfunction

  task automatic predict_answer(
    input  op_t               op,
    input  logic [BASE_W-1:0] base,
    input  logic [LIMIT_W-1:0] limit,
    input  logic [TYPE_W-1:0] typ,
    input  logic              gran,
    input  logic [IDX_W-1:0]  idx,
    output answer_t           a
  );
    int                slot;
    logic [DESC_W-1:0] d;
    a    = '0;
    a.err = ERR_OK;
    slot = -1;
    case (op)
      OP_CREATE: begin
        for (int i = 0; i < IDX_SPACE; i++)
          if (slot < 0 && !in_use[i]) slot = i;
        if (slot >= 0) begin
          d                 = build_descriptor(base, limit, typ, gran);
          table_words[slot] = d;
          in_use[slot]      = 1'b1;
          a.index           = IDX_W'(slot);
          a.selector        = selector_for(IDX_W'(slot), d);
          a.used            = 1'b1;
          a.desc            = d;
        end else begin
          a.err = ERR_FULL;
        end
      end
      OP_DELETE: begin
        table_words[idx] = '0;
        in_use[idx]      = 1'b0;
        a.index          = idx;
        a.selector       = {idx, 3'b000};
      end
      default: begin
        a.index = idx;
        if (in_use[idx]) begin
          a.used     = 1'b1;
          a.desc     = table_words[idx];
          a.selector = selector_for(idx, table_words[idx]);
        end else begin
          a.selector = {idx, 3'b000};
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < IDX_SPACE; i++) begin
        in_use[i]      = 1'b0;
        table_words[i] = '0;
      end
      in_use[0] = 1'b1;
      awaited_answers.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      // compare first: a result never belongs to an item taken at the same edge
      if (out_valid && out_ready) begin
        seen = '{out_result_index, out_selector, out_occupied, out_descriptor,
                 out_error_code};
        if (awaited_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: idx %0d sel %0d occ %0b desc %h err %0b",
                     seen.index, seen.selector, seen.used, seen.desc, seen.err);
        end else begin
          wanted = awaited_answers.pop_front();
          if (seen !== wanted) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected idx %0d sel %0d occ %0b desc %h err %0b",
                       wanted.index, wanted.selector, wanted.used, wanted.desc, wanted.err);
              $display("          got      idx %0d sel %0d occ %0b desc %h err %0b",
                       seen.index, seen.selector, seen.used, seen.desc, seen.err);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_answer(op_t'(in_opcode), in_seg_base, in_seg_limit, in_access_type,
                       in_granularity, in_entry_index, wanted);
        awaited_answers.push_back(wanted);
      end
      outstanding = awaited_answers.size();
    end
  end

endmodule

// ----- bench/tb_descriptor_table_allocator_unit.sv -----
module tb_descriptor_table_allocator_unit
  import dta_pkg::*;
();

  // Stimulus mixes: even spread, table filling, table draining.
  typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN} mix_t;

  localparam int RANDOM_ITEMS = 1200;
  localparam int EPOCH        = 150;
  localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
  localparam int HOLD_AT      = 200;   // result count that triggers the hold-off
  localparam int PAUSE_AT     = 600;   // random item before which the sender drains
  localparam int SETTLE       = 20;    // cycles after the last result

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_opcode;
  logic [BASE_W-1:0]  in_seg_base;
  logic [LIMIT_W-1:0] in_seg_limit;
  logic [TYPE_W-1:0]  in_access_type;
  logic               in_granularity;
  logic [IDX_W-1:0]   in_entry_index;
  logic               out_valid;
  logic               out_ready;
  logic [IDX_W-1:0]   out_result_index;
  logic [SEL_W-1:0]   out_selector;
  logic               out_occupied;
  logic [DESC_W-1:0]  out_descriptor;
  logic               out_error_code;

  int mismatches;
  int outstanding;

  // Shadow of the occupancy map at issue time. Items are handled strictly in
  // order, so this matches the block's state when each item is processed.
  bit used_map [IDX_SPACE];
  bit null_written;   // entry 0 has held a created descriptor
  int used_count;
  int peak_used;
  int n_create;
  int n_full;
  int n_delete;
  int n_query;
  int sent;
  bit send_quiet;

  mix_t plan [8] = '{MIX_EVEN, MIX_FILL, MIX_FILL, MIX_FILL,
                     MIX_DRAIN, MIX_DRAIN, MIX_EVEN, MIX_FILL};

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  descriptor_table_allocator_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_seg_base      (in_seg_base),
    .in_seg_limit     (in_seg_limit),
    .in_access_type   (in_access_type),
    .in_granularity   (in_granularity),
    .in_entry_index   (in_entry_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_index (out_result_index),
    .out_selector     (out_selector),
    .out_occupied     (out_occupied),
    .out_descriptor   (out_descriptor),
    .out_error_code   (out_error_code)
  );

  descriptor_answer_checker u_answers (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_seg_base      (in_seg_base),
    .in_seg_limit     (in_seg_limit),
    .in_access_type   (in_access_type),
    .in_granularity   (in_granularity),
    .in_entry_index   (in_entry_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_index (out_result_index),
    .out_selector     (out_selector),
    .out_occupied     (out_occupied),
    .out_descriptor   (out_descriptor),
    .out_error_code   (out_error_code),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // Offer one item. Called at a falling edge; returns at the falling edge after
  // acceptance with in_valid still high, so a back-to-back item never lowers and
  // raises it in the same step.
  task automatic offer(
    input op_t               op,
    input logic [BASE_W-1:0] base,
    input logic [LIMIT_W-1:0] limit,
    input logic [TYPE_W-1:0] typ,
    input logic              gran,
    input logic [IDX_W-1:0]  idx
  );
    int gap;
    int slot;
    // every 40 items, maybe switch to a stretch with no gaps at all
    if (sent % 40 == 0) send_quiet = ($urandom_range(0, 2) == 0);
    gap = send_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_seg_base    <= base;
    in_seg_limit   <= limit;
    in_access_type <= typ;
    in_granularity <= gran;
    in_entry_index <= idx;

    // advance the shadow the same way the block will
    slot = -1;
    case (op)
      OP_CREATE: begin
        n_create++;
        for (int i = 0; i < IDX_SPACE; i++)
          if (slot < 0 && !used_map[i]) slot = i;
        if (slot < 0) begin
          n_full++;
        end else begin
          used_map[slot] = 1'b1;
          used_count++;
          if (slot == 0) null_written = 1'b1;
          if (used_count > peak_used) peak_used = used_count;
        end
      end
      OP_DELETE: begin
        n_delete++;
        if (used_map[idx]) used_count--;
        used_map[idx] = 1'b0;
      end
      default: n_query++;
    endcase

    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  // Random entry that is in use, or a random entry if the table is empty.
  function automatic logic [IDX_W-1:0] pick_used();
    int start;
    start = $urandom_range(0, IDX_SPACE - 1);
    for (int k = 0; k < IDX_SPACE; k++)
      if (used_map[(start + k) % IDX_SPACE]) return IDX_W'((start + k) % IDX_SPACE);
    return IDX_W'(start);
  endfunction

  task automatic offer_random(input mix_t mix);
    int               roll;
    int               create_pct;
    int               delete_pct;
    op_t              op;
    logic [IDX_W-1:0] idx;
    case (mix)
      MIX_FILL:  begin create_pct = 90; delete_pct = 95; end
      MIX_DRAIN: begin create_pct = 15; delete_pct = 75; end
      default:   begin create_pct = 40; delete_pct = 70; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < create_pct)      op = OP_CREATE;
    else if (roll < delete_pct) op = OP_DELETE;
    else                        op = ($urandom_range(0, 9) == 0) ? OP_SPARE : OP_QUERY;

    // mostly address live entries; the rest is noise over the whole index range
    idx = ($urandom_range(0, 3) != 0) ? pick_used() : IDX_W'($urandom);
    // never read the null entry while it is marked but was never written
    if (op != OP_CREATE && op != OP_DELETE && idx == 0 && used_map[0] && !null_written)
      idx = IDX_W'($urandom_range(1, IDX_SPACE - 1));

    offer(op, $urandom, LIMIT_W'($urandom), TYPE_W'($urandom), 1'($urandom), idx);
  endtask

  // Receiver: per result, hold out_ready low for a random number of cycles,
  // with calm stretches and one long hold-off that backs the block up.
  initial begin
    int wait_cycles;
    int taken;
    bit calm;
    out_ready = 1'b0;
    taken     = 0;
    calm      = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      wait_cycles = calm ? 0 : $urandom_range(0, 17);
      if (taken == HOLD_AT) wait_cycles = LONG_HOLD;
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_QUERY;
    in_seg_base    = '0;
    in_seg_limit   = '0;
    in_access_type = '0;
    in_granularity = 1'b0;
    in_entry_index = '0;
    for (int i = 0; i < IDX_SPACE; i++) used_map[i] = 1'b0;
    used_map[0]  = 1'b1;
    null_written = 1'b0;
    used_count   = 1;
    peak_used    = 1;
    n_create     = 0;
    n_full       = 0;
    n_delete     = 0;
    n_query      = 0;
    sent         = 0;
    send_quiet   = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: free query, field extremes and every DPL on create.
    offer(OP_QUERY,  32'h0,        20'h0,     8'h00, 1'b0, 8'd1);
    offer(OP_CREATE, 32'h0,        20'h0,     8'h00, 1'b0, 8'd0);
    offer(OP_CREATE, 32'hFFFF_FFFF, 20'hFFFFF, 8'hFF, 1'b1, 8'hFF);
    offer(OP_CREATE, 32'h1234_5678, 20'hABCDE, 8'h9A, 1'b0, 8'h00);
    offer(OP_CREATE, 32'h00AB_CDEF, 20'h00FFF, 8'h20, 1'b1, 8'h55);
    offer(OP_CREATE, 32'hFE00_0001, 20'hF0000, 8'hC0, 1'b0, 8'hAA);
    offer(OP_QUERY,  32'h0,        20'h0,     8'h00, 1'b0, 8'd2);
    offer(OP_SPARE,  32'h0,        20'h0,     8'h00, 1'b0, 8'd3);
    // delete, query the hole, delete it again while free, refill it
    offer(OP_DELETE, 32'h0,        20'h0,     8'h00, 1'b0, 8'd2);
    offer(OP_QUERY,  32'h0,        20'h0,     8'h00, 1'b0, 8'd2);
    offer(OP_DELETE, 32'h0,        20'h0,     8'h00, 1'b0, 8'd2);
    offer(OP_CREATE, 32'h8000_0000, 20'h80000, 8'h60, 1'b1, 8'd0);
    // top of the index range, never used
    offer(OP_DELETE, 32'h0,        20'h0,     8'h00, 1'b0, 8'd255);
    offer(OP_QUERY,  32'h0,        20'h0,     8'h00, 1'b0, 8'd255);
    // free the null entry, then reuse it
    offer(OP_DELETE, 32'h0,        20'h0,     8'h00, 1'b0, 8'd0);
    offer(OP_QUERY,  32'h0,        20'h0,     8'h00, 1'b0, 8'd0);
    offer(OP_CREATE, 32'hDEAD_BEEF, 20'h12345, 8'hF2, 1'b1, 8'h7F);
    offer(OP_QUERY,  32'h0,        20'h0,     8'h00, 1'b0, 8'd0);
    offer(OP_SPARE,  32'h0,        20'h0,     8'h00, 1'b0, 8'd0);
    offer(OP_DELETE, 32'h0,        20'h0,     8'h00, 1'b0, 8'd3);
    offer(OP_QUERY,  32'h0,        20'h0,     8'h00, 1'b0, 8'd3);

    // Random: epochs of fill and drain so the table runs full and empties again.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PAUSE_AT) begin
        // drop valid and hold until every result is back
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
      end
      offer_random(plan[n / EPOCH]);
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE) @(negedge clk);

    $display("Run covered %0d items: %0d creates (%0d on a full table), %0d deletes,",
             sent, n_create, n_full, n_delete);
    $display("%0d queries; peak occupancy %0d of %0d entries, %0d mismatches.",
             n_query, peak_used, IDX_SPACE, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
